>>> hw/rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// SSE parser package
// Result kinds, character codes and the item types passed between the
// front end, the result queue and the output stage.
// ----------------------------------------------------------------------------
package sse_pkg;

    // Result kinds as they appear on the output port.
    localparam logic [2:0] KIND_DATA_BYTE   = 3'd0;
    localparam logic [2:0] KIND_EVENT_START = 3'd1;
    localparam logic [2:0] KIND_EVENT_BYTE  = 3'd2;
    localparam logic [2:0] KIND_ID_START    = 3'd3;
    localparam logic [2:0] KIND_ID_BYTE     = 3'd4;
    localparam logic [2:0] KIND_DISPATCH    = 3'd5;

    // Stream characters with a special meaning.
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // One result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       event_flag;
        logic       has_id;
    } result_t;

    // All results caused by one input item (one or two).
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

    // Read side of the result queue as seen by the output stage.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_rd_t;

endpackage

>>> hw/rtl/sse_event_stream_parser.sv
// An accepted item's results are written to the result queue, then loaded into the output register.
// Throughput: one item per cycle while in_stall is low; an item that causes two results (a line opening
// together with its first value byte) holds the single output register for both of them in turn.
// The result queue of QUEUE_DEPTH entries absorbs those bursts and output stalls.
// Reset: rst_n clears the line state, the queue and the output valid at once.
// ----------------------------------------------------------------------------
// SSE event stream parser
// Streaming server-sent events line parser: front end, result queue and
// output stage.
// ----------------------------------------------------------------------------
module sse_event_stream_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] byte_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] value,
    output logic       event_flag,
    output logic       has_id,
    output logic       last
);
    import sse_pkg::*;

    logic      queue_full;
    logic      push;
    entry_t    push_entry;
    logic      pop;
    queue_rd_t rd;

    // Front end: line state and result building.
    sse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .byte_req   (byte_req),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue between the two halves.
    sse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .rd         (rd)
    );

    // Output stage.
    sse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (rd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .value      (value),
        .event_flag (event_flag),
        .has_id     (has_id),
        .last       (last)
    );

endmodule

>>> hw/rtl/sse_front.sv
// ----------------------------------------------------------------------------
// SSE parser front end
// Accepts one stream byte or reset command per cycle unless stalled by a full
// queue, tracks the line state and builds the item's results as one queue entry.
// ----------------------------------------------------------------------------
module sse_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            command,
    input  logic [7:0]      byte_req,
    input  logic            queue_full,
    output logic            push,
    output sse_pkg::entry_t push_entry
);
    import sse_pkg::*;

    // Line phase codes.
    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_COLON = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    // Field codes.
    localparam logic [1:0] FLD_NONE  = 2'd0;
    localparam logic [1:0] FLD_DATA  = 2'd1;
    localparam logic [1:0] FLD_EVENT = 2'd2;
    localparam logic [1:0] FLD_ID    = 2'd3;

    // Expected name character at a position, per template; zero past its end.
    function automatic logic [7:0] data_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h64;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] event_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h76;
            3'd2:    ch = 8'h65;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] id_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h69;
            3'd1:    ch = 8'h64;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Field selected by a finished name.
    function automatic logic [1:0] decide_field(input logic [2:0] len,
                                                input logic [2:0] hit_mask);
        logic [1:0] fld;
        if (len == 3'd4 && hit_mask[0])
            fld = FLD_DATA;
        else if (len == 3'd5 && hit_mask[1])
            fld = FLD_EVENT;
        else if (len == 3'd2 && hit_mask[2])
            fld = FLD_ID;
        else
            fld = FLD_NONE;
        return fld;
    endfunction

    logic [1:0] phase_reg,    phase_next;
    logic [2:0] name_cnt_reg, name_cnt_next;
    logic [2:0] matches_reg,  matches_next;
    logic [1:0] field_reg,    field_next;
    logic       started_reg,  started_next;
    logic       data_ne_reg,  data_ne_next;
    logic       ev_seen_reg,  ev_seen_next;
    logic       id_seen_reg,  id_seen_next;

    logic       accept;
    logic [1:0] fld;
    logic       open_vld;
    result_t    open_res;
    logic       byte_vld;
    result_t    byte_res;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // Next line state and the results of the current item.
    always_comb
    begin
        phase_next    = phase_reg;
        name_cnt_next = name_cnt_reg;
        matches_next  = matches_reg;
        field_next    = field_reg;
        started_next  = started_reg;
        data_ne_next  = data_ne_reg;
        ev_seen_next  = ev_seen_reg;
        id_seen_next  = id_seen_reg;
        open_vld      = 1'b0;
        open_res      = '0;
        byte_vld      = 1'b0;
        byte_res      = '0;
        fld           = field_reg;

        if (command)
        begin
            phase_next    = PH_NAME;
            name_cnt_next = 3'd0;
            matches_next  = 3'b111;
            field_next    = FLD_NONE;
            started_next  = 1'b0;
            data_ne_next  = 1'b0;
            ev_seen_next  = 1'b0;
            id_seen_next  = 1'b0;
        end
        else if (byte_req == CHAR_CR)
        begin
            // Carriage returns are dropped.
        end
        else if (byte_req == CHAR_LF)
        begin
            if (phase_reg == PH_NAME && name_cnt_reg == 3'd0)
            begin
                // Blank line: dispatch if anything was collected.
                if (data_ne_reg || ev_seen_reg || id_seen_reg)
                begin
                    open_vld            = 1'b1;
                    open_res.kind       = KIND_DISPATCH;
                    open_res.event_flag = ev_seen_reg;
                    open_res.has_id     = id_seen_reg;
                    data_ne_next        = 1'b0;
                    ev_seen_next        = 1'b0;
                    id_seen_next        = 1'b0;
                end
            end
            else
            begin
                if (phase_reg == PH_NAME)
                    fld = decide_field(name_cnt_reg, matches_reg);
                // Line end still owes its join or start mark.
                if (!started_reg)
                begin
                    if (fld == FLD_DATA && data_ne_reg)
                    begin
                        open_vld       = 1'b1;
                        open_res.kind  = KIND_DATA_BYTE;
                        open_res.value = CHAR_LF;
                    end
                    else if (fld == FLD_EVENT)
                    begin
                        open_vld      = 1'b1;
                        open_res.kind = KIND_EVENT_START;
                        ev_seen_next  = 1'b1;
                    end
                    else if (fld == FLD_ID)
                    begin
                        open_vld      = 1'b1;
                        open_res.kind = KIND_ID_START;
                        id_seen_next  = 1'b1;
                    end
                end
            end
            phase_next    = PH_NAME;
            name_cnt_next = 3'd0;
            matches_next  = 3'b111;
            field_next    = FLD_NONE;
            started_next  = 1'b0;
        end
        else if (phase_reg == PH_NAME)
        begin
            if (byte_req == CHAR_COLON)
            begin
                field_next = decide_field(name_cnt_reg, matches_reg);
                phase_next = PH_COLON;
            end
            else
            begin
                // Match the name byte against each template on the fly.
                if (name_cnt_reg >= 3'd4 || data_char(name_cnt_reg) != byte_req)
                    matches_next[0] = 1'b0;
                if (name_cnt_reg >= 3'd5 || event_char(name_cnt_reg) != byte_req)
                    matches_next[1] = 1'b0;
                if (name_cnt_reg >= 3'd2 || id_char(name_cnt_reg) != byte_req)
                    matches_next[2] = 1'b0;
                if (name_cnt_reg != 3'd7)
                    name_cnt_next = name_cnt_reg + 3'd1;
            end
        end
        else
        begin
            phase_next = PH_VALUE;
            // One space right after the colon is stripped.
            if (!(phase_reg == PH_COLON && byte_req == CHAR_SPACE) &&
                field_reg != FLD_NONE)
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    if (field_reg == FLD_DATA)
                    begin
                        if (data_ne_reg)
                        begin
                            open_vld       = 1'b1;
                            open_res.kind  = KIND_DATA_BYTE;
                            open_res.value = CHAR_LF;
                        end
                    end
                    else if (field_reg == FLD_EVENT)
                    begin
                        open_vld      = 1'b1;
                        open_res.kind = KIND_EVENT_START;
                        ev_seen_next  = 1'b1;
                    end
                    else
                    begin
                        open_vld      = 1'b1;
                        open_res.kind = KIND_ID_START;
                        id_seen_next  = 1'b1;
                    end
                end
                byte_vld       = 1'b1;
                byte_res.value = byte_req;
                if (field_reg == FLD_DATA)
                begin
                    byte_res.kind = KIND_DATA_BYTE;
                    data_ne_next  = 1'b1;
                end
                else if (field_reg == FLD_EVENT)
                    byte_res.kind = KIND_EVENT_BYTE;
                else
                    byte_res.kind = KIND_ID_BYTE;
            end
        end
    end

    // Pack the item's results into one queue entry.
    always_comb
    begin
        push_entry = '0;
        if (open_vld)
        begin
            push_entry.first  = open_res;
            push_entry.second = byte_res;
            push_entry.two    = byte_vld;
        end
        else
        begin
            push_entry.first = byte_res;
        end
        push = accept && (open_vld || byte_vld);
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NAME;
            name_cnt_reg <= 3'd0;
            matches_reg  <= 3'b111;
            field_reg    <= FLD_NONE;
            started_reg  <= 1'b0;
            data_ne_reg  <= 1'b0;
            ev_seen_reg  <= 1'b0;
            id_seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            name_cnt_reg <= name_cnt_next;
            matches_reg  <= matches_next;
            field_reg    <= field_next;
            started_reg  <= started_next;
            data_ne_reg  <= data_ne_next;
            ev_seen_reg  <= ev_seen_next;
            id_seen_reg  <= id_seen_next;
        end
    end

endmodule

>>> hw/rtl/sse_queue.sv
// ----------------------------------------------------------------------------
// SSE result queue
// Small FIFO of result entries between the front end and the output stage.
// ----------------------------------------------------------------------------
module sse_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sse_pkg::entry_t    push_entry,
    output logic               full,
    input  logic               pop,
    output sse_pkg::queue_rd_t rd
);
    import sse_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    entry_t              slots_reg [DEPTH];
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.entry = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd.valid;

    // Pointer and count updates with wrap at the last slot.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> hw/rtl/sse_back.sv
// ----------------------------------------------------------------------------
// SSE output stage
// Takes queue entries apart into single result items and holds each in an
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module sse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sse_pkg::queue_rd_t rd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [7:0]         value,
    output logic               event_flag,
    output logic               has_id,
    output logic               last
);
    import sse_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    sub_reg,       sub_next;
    result_t res_reg,       res_next;
    logic    last_reg,      last_next;
    logic    load;

    // Load a new result whenever the output register is free or being taken.
    always_comb
    begin
        load           = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg;
        sub_next       = sub_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = rd.valid;
            if (rd.valid)
            begin
                res_next  = sub_reg ? rd.entry.second : rd.entry.first;
                last_next = sub_reg || !rd.entry.two;
                sub_next  = !sub_reg && rd.entry.two;
                pop       = sub_reg || !rd.entry.two;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = res_reg.kind;
    assign value      = res_reg.value;
    assign event_flag = res_reg.event_flag;
    assign has_id     = res_reg.has_id;
    assign last       = last_reg;

endmodule

>>> hw/rtl/sse_checker.sv
// ----------------------------------------------------------------------------
// SSE parser port checker
// Checks the result stream seen on the top-level ports.
// ----------------------------------------------------------------------------
module sse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] kind,
    input logic [7:0] value,
    input logic       event_flag,
    input logic       has_id,
    input logic       last
);
    import sse_pkg::*;

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value) &&
            $stable(last))
    else $error("stalled result changed");

    // Only defined kinds are sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= KIND_DISPATCH)
    else $error("undefined result kind");

    // A dispatch is always the only and last result of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DISPATCH |-> last && value == 8'h00)
    else $error("dispatch not marked last");

    // The event and id flags appear only on a dispatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DISPATCH |-> !event_flag && !has_id)
    else $error("flags set outside dispatch");

    // A value start mark carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EVENT_START || kind == KIND_ID_START) |-> value == 8'h00)
    else $error("start mark carries a byte");

endmodule

bind sse_event_stream_parser sse_checker u_sse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .event_flag (event_flag),
    .has_id     (has_id),
    .last       (last)
);
